// ===== hdl/psg_pkg.sv =====
package psg_pkg;

    localparam int VOL_BITS = 15;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_BEEP = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_STEP_NUM = 2'd0,
        CFG_STEP_DEN = 2'd1,
        CFG_STEREO   = 2'd2,
        CFG_BEEP_VOL = 2'd3
    } t_cfg_index;

    localparam logic [1:0] MIX_ABC = 2'd1;
    localparam logic [1:0] MIX_ACB = 2'd2;

    // sound register numbers with side effects
    localparam logic [3:0] REG_NOISE  = 4'd6;
    localparam logic [3:0] REG_MIXER  = 4'd7;
    localparam logic [3:0] REG_VOL_A  = 4'd8;
    localparam logic [3:0] REG_VOL_C  = 4'd10;
    localparam logic [3:0] REG_ENV_LO = 4'd11;
    localparam logic [3:0] REG_ENV_HI = 4'd12;
    localparam logic [3:0] REG_SHAPE  = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DIV1,
        ST_TICK,
        ST_OUT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;     // capture the accepted item
        logic reg_wr;    // write sound register, start scaling
        logic beep_wr;
        logic mul_go;    // multiply raw period by step_num
        logic div_step;
        logic div1_go;   // divide step_num alone (zero fallback)
        logic commit;    // store scaled period
        logic tick;      // step envelope and channels, load output
    } t_cmd;

    typedef struct packed {
        logic is_period; // latched write targets a period register
        logic div_done;
        logic need_min;  // scaled result was zero
        t_kind kind;
    } t_stat;

    function automatic logic [VOL_BITS-1:0] vol_tab(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:  v = 16'h0000;
            4'd1:  v = 16'h0344;
            4'd2:  v = 16'h04BC;
            4'd3:  v = 16'h06ED;
            4'd4:  v = 16'h0A3B;
            4'd5:  v = 16'h0F23;
            4'd6:  v = 16'h1515;
            4'd7:  v = 16'h2277;
            4'd8:  v = 16'h2898;
            4'd9:  v = 16'h4142;
            4'd10: v = 16'h5B2B;
            4'd11: v = 16'h726C;
            4'd12: v = 16'h9069;
            4'd13: v = 16'hB555;
            4'd14: v = 16'hD79B;
            default: v = 16'hFFFF;
        endcase
        return v[15:1];
    endfunction

    // x / 3 for 15-bit x via reciprocal multiply
    function automatic logic [VOL_BITS-1:0] div3(input logic [VOL_BITS-1:0] x);
        logic [31:0] p;
        p = {17'd0, x} * 32'd43691;
        return p[31:17];
    endfunction

endpackage

// ===== hdl/psg_if.sv =====
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] reg_index;
    logic [7:0] write_value;
    modport source (output valid, kind, reg_index, write_value, input ready);
    modport sink (input valid, kind, reg_index, write_value, output ready);
endinterface

interface psg_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] level_a;
    logic [14:0] level_b;
    logic [14:0] level_c;
    logic [14:0] beeper_level;
    logic [14:0] left_sample;
    logic [14:0] right_sample;
    modport source (output valid, level_a, level_b, level_c, beeper_level,
                    left_sample, right_sample, input ready);
    modport sink (input valid, level_a, level_b, level_c, beeper_level,
                  left_sample, right_sample, output ready);
endinterface

interface psg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/psg_ctrl.sv =====
module psg_ctrl
    import psg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // decode the latched item
                case (i_stat.kind)
                    KIND_REG:  n_state = i_stat.is_period ? ST_MUL : ST_IDLE;
                    KIND_TICK: n_state = i_out_busy ? ST_OUT : ST_TICK;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.need_min ? ST_DIV1 : ST_IDLE;
                end
            end
            ST_DIV1: begin
                if (i_stat.div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_OUT: begin
                o_cmd.reg_wr  = (i_stat.kind == KIND_REG);
                o_cmd.beep_wr = (i_stat.kind == KIND_BEEP);
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = !i_stat.div_done;
                o_cmd.commit   = i_stat.div_done;
                o_cmd.div1_go  = i_stat.div_done && i_stat.need_min;
            end
            ST_DIV1: begin
                o_cmd.div_step = !i_stat.div_done;
                o_cmd.commit   = i_stat.div_done;
            end
            ST_TICK: begin
                o_cmd.tick = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/psg_datapath.sv =====
module psg_datapath
    import psg_pkg::*;
#(
    parameter int PERIOD_BITS = 32,
    parameter int LFSR_BITS   = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_reg_index,
    input  logic [7:0]  i_write_value,
    input  logic [15:0] i_step_num,
    input  logic [15:0] i_step_den,
    input  logic [1:0]  i_stereo_mode,
    input  logic [3:0]  i_beeper_volume,
    output logic [VOL_BITS-1:0] o_lv [6]
);

    localparam int PROD_BITS = 32;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

    t_kind       r_kind;
    logic [3:0]  r_idx;
    logic [7:0]  r_val;
    logic [7:0]  r_regs [14];
    logic [PERIOD_BITS-1:0] r_tone_per [3];
    logic [PERIOD_BITS-1:0] r_tone_cnt [3];
    logic [PERIOD_BITS-1:0] r_noise_cnt [3];
    logic [LFSR_BITS-1:0]   r_lfsr [3];
    logic [PERIOD_BITS-1:0] r_noise_per, r_env_per;
    // envelope count runs up to twice the period
    logic [PERIOD_BITS:0]   r_env_cnt;
    logic [3:0]  r_env_lvl;
    logic        r_cont, r_alt, r_hold, r_up, r_held;
    logic [VOL_BITS-1:0] r_beep;

    // scaling datapath
    logic [15:0] r_raw;
    logic [PROD_BITS-1:0] r_rem_q;   // dividend shifting into quotient
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic        r_busy, r_min_pass;

    logic [15:0] den_eff;
    assign den_eff = (i_step_den == 16'd0) ? 16'd1 : i_step_den;

    // register write stores the new byte and assembles raw from it and the banked partner byte
    logic [1:0] tgt;   // 0..2 tone channel for tone registers; noise/env select handled by r_idx
    always_comb begin
        tgt = r_idx[2:1];
    end

    logic is_tone, is_noise, is_env;
    assign is_tone  = (r_idx < REG_NOISE);
    assign is_noise = (r_idx == REG_NOISE);
    assign is_env   = (r_idx == REG_ENV_LO) || (r_idx == REG_ENV_HI);

    logic [16:0] trial;
    assign trial = {r_rem[15:0], r_rem_q[PROD_BITS-1]} - {1'b0, r_den};
    logic [16:0] shifted;
    assign shifted = {r_rem[15:0], r_rem_q[PROD_BITS-1]};

    logic [PERIOD_BITS-1:0] q_ext, q_final;
    always_comb begin
        q_ext = PERIOD_BITS'({{PROD_BITS{1'b0}}, r_rem_q});
        q_final = r_min_pass ? (is_env ? (q_ext >> 1) : q_ext) : q_ext;
    end

    assign o_stat.is_period = is_tone || is_noise || is_env;
    assign o_stat.div_done  = (r_cnt == '0) && !i_cmd.mul_go && r_busy;
    assign o_stat.need_min  = !r_min_pass && (q_ext == '0);
    assign o_stat.kind      = r_kind;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= t_kind'(i_kind);
            r_idx  <= i_reg_index;
            r_val  <= i_write_value;
        end
        if (i_cmd.mul_go) begin
            r_rem_q <= PROD_BITS'({16'd0, r_raw} * {16'd0, i_step_num});
            r_rem   <= '0;
            r_den   <= den_eff;
            r_cnt   <= CNT_BITS'(PROD_BITS);
            r_min_pass <= 1'b0;
        end else if (i_cmd.div1_go) begin
            r_rem_q <= PROD_BITS'(i_step_num);
            r_rem   <= '0;
            r_cnt   <= CNT_BITS'(PROD_BITS);
            r_min_pass <= 1'b1;
        end else if (i_cmd.div_step) begin
            // restoring division, one quotient bit a cycle
            if (!trial[16]) begin
                r_rem <= trial;
            end else begin
                r_rem <= shifted;
            end
            r_rem_q <= {r_rem_q[PROD_BITS-2:0], !trial[16]};
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.mul_go) begin
            r_busy <= 1'b1;
        end else if (i_cmd.commit && !i_cmd.div1_go) begin
            r_busy <= 1'b0;
        end
    end

    // envelope step, computed combinationally for a tick
    logic [PERIOD_BITS:0] env_lim;
    logic [3:0] e_lvl;
    logic       e_up, e_held;
    logic [PERIOD_BITS:0] e_cnt;
    always_comb begin
        env_lim = r_alt ? {1'b0, r_env_per} : {r_env_per, 1'b0};
        e_lvl = r_env_lvl;
        e_up = r_up;
        e_held = r_held;
        e_cnt = r_env_cnt;
        if (!r_held) begin
            if (env_lim > r_env_cnt) begin
                e_cnt = r_env_cnt + 1'b1;
            end else begin
                e_cnt = '0;
                if (r_up) begin
                    if (r_env_lvl < 4'd15) e_lvl = r_env_lvl + 1'b1;
                    else if (!r_cont) begin e_held = 1'b1; e_lvl = 4'd0; end
                    else if (r_hold) begin
                        if (r_alt) e_lvl = 4'd0;
                        e_held = 1'b1;
                    end else if (r_alt) e_up = 1'b0;
                    else e_lvl = 4'd0;
                end else begin
                    if (r_env_lvl > 4'd0) e_lvl = r_env_lvl - 1'b1;
                    else if (!r_cont) e_held = 1'b1;
                    else if (r_hold) begin
                        if (r_alt) e_lvl = 4'd15;
                        e_held = 1'b1;
                    end else if (r_alt) e_up = 1'b1;
                    else e_lvl = 4'd15;
                end
            end
        end
    end

    logic [VOL_BITS-1:0] ch_lv [3];
    logic [PERIOD_BITS-1:0] t_cnt_n [3];
    logic [PERIOD_BITS-1:0] n_cnt_n [3];
    logic [LFSR_BITS-1:0]   lfsr_n [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [PERIOD_BITS-1:0] tc;
            logic tone, noise, on;
            logic [7:0] vr;
            tc = (r_tone_cnt[c] >= r_tone_per[c]) ? '0 : r_tone_cnt[c];
            tone = tc < (r_tone_per[c] >> 1);
            t_cnt_n[c] = tc + 1'b1;
            lfsr_n[c] = r_lfsr[c];
            n_cnt_n[c] = r_noise_cnt[c] + 1'b1;
            if (r_noise_cnt[c] >= r_noise_per) begin
                lfsr_n[c] = {r_lfsr[c][0] ^ r_lfsr[c][3], r_lfsr[c][LFSR_BITS-1:1]};
                n_cnt_n[c] = PERIOD_BITS'(1);
            end
            noise = lfsr_n[c][0];
            on = ((tone || r_regs[REG_MIXER][c]) && (noise || r_regs[REG_MIXER][c+3]))
                 || (r_tone_per[c] == '0);
            vr = r_regs[4'(int'(REG_VOL_A) + c)];
            ch_lv[c] = !on ? '0 : (vr[4] ? vol_tab(e_lvl) : vol_tab(vr[3:0]));
        end
    end

    logic [VOL_BITS-1:0] mix_l, mix_r, quarter;
    always_comb begin
        quarter = VOL_BITS'((17'(ch_lv[0] >> 2) + 17'(ch_lv[1] >> 2))
                  + (17'(ch_lv[2] >> 2) + 17'(r_beep >> 2)));
        if (i_stereo_mode == MIX_ABC) begin
            mix_l = div3(ch_lv[0]) + div3(ch_lv[1]) + div3(r_beep);
            mix_r = div3(ch_lv[2]) + div3(ch_lv[1]) + div3(r_beep);
        end else if (i_stereo_mode == MIX_ACB) begin
            mix_l = div3(ch_lv[0]) + div3(ch_lv[2]) + div3(r_beep);
            mix_r = div3(ch_lv[1]) + div3(ch_lv[2]) + div3(r_beep);
        end else begin
            mix_l = quarter;
            mix_r = quarter;
        end
    end

    logic [7:0] wv;
    always_comb begin
        wv = r_val;
        if (r_idx < REG_NOISE && r_idx[0]) wv = {4'd0, r_val[3:0]};
        else if (r_idx == REG_NOISE) wv = {3'd0, r_val[4:0]};
        else if (r_idx >= REG_VOL_A && r_idx <= REG_VOL_C) wv = {3'd0, r_val[4:0]};
        else if (r_idx == REG_SHAPE) wv = {4'd0, r_val[3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 14; i++) r_regs[i] <= '0;
            for (int c = 0; c < 3; c++) begin
                r_tone_per[c] <= '0;
                r_tone_cnt[c] <= '0;
                r_noise_cnt[c] <= '0;
                r_lfsr[c] <= LFSR_BITS'(1);
            end
            r_noise_per <= '0;
            r_env_per <= '0;
            r_env_cnt <= '0;
            r_env_lvl <= '0;
            {r_cont, r_alt, r_hold, r_up, r_held} <= '0;
            r_beep <= '0;
            r_raw <= '0;
            for (int k = 0; k < 6; k++) o_lv[k] <= '0;
        end else begin
            if (i_cmd.reg_wr && r_idx < 4'd14) begin
                r_regs[r_idx] <= wv;
                if (is_tone) begin
                    r_raw <= r_idx[0] ? {4'd0, wv[3:0], r_regs[{1'b0, tgt, 1'b0}]}
                                      : {4'd0, r_regs[{1'b0, tgt, 1'b1}][3:0], wv};
                end else if (is_noise) begin
                    r_raw <= {8'd0, wv};
                end else if (r_idx == REG_ENV_LO) begin
                    r_raw <= {r_regs[REG_ENV_HI], wv};
                end else if (r_idx == REG_ENV_HI) begin
                    r_raw <= {wv, r_regs[REG_ENV_LO]};
                end
                if (r_idx == REG_SHAPE) begin
                    if (wv[3]) begin
                        r_alt  <= wv[1];
                        r_hold <= wv[0];
                    end
                    r_cont <= wv[3];
                    r_up   <= wv[2];
                    r_held <= 1'b0;
                    r_env_cnt <= '0;
                    r_env_lvl <= wv[2] ? 4'd0 : 4'd15;
                end
            end
            if (i_cmd.beep_wr) begin
                r_beep <= (r_val != 8'd0) ? vol_tab(i_beeper_volume) : '0;
            end
            if (i_cmd.commit && !i_cmd.div1_go) begin
                if (is_tone) r_tone_per[tgt] <= q_final;
                else if (is_noise) r_noise_per <= q_final;
                else r_env_per <= q_final;
            end
            if (i_cmd.tick) begin
                r_env_cnt <= e_cnt;
                r_env_lvl <= e_lvl;
                r_up <= e_up;
                r_held <= e_held;
                for (int c = 0; c < 3; c++) begin
                    r_tone_cnt[c] <= t_cnt_n[c];
                    r_noise_cnt[c] <= n_cnt_n[c];
                    r_lfsr[c] <= lfsr_n[c];
                    o_lv[c] <= ch_lv[c];
                end
                o_lv[3] <= r_beep;
                o_lv[4] <= mix_l;
                o_lv[5] <= mix_r;
            end
        end
    end

endmodule

// ===== hdl/psg_three_channel_sound_generator.sv =====
// Three-channel sound generator.
// Channels: in (kind, reg_index, write_value), out (six 15-bit levels),
// cfg (index, data) for step_num, step_den, stereo_mode, beeper_volume.
// An item is taken when valid and ready are high on a clock edge.
// A beeper write or a plain register write is latched, then applied.
// A period register write also runs one multiply by step_num,
// then a 32-step restoring divide by step_den; a zero quotient runs a
// second 32-step divide of step_num alone.
// A tick yields one result item, held in the output
// register until taken; a tick waits while that register is still full,
// so a stalled receiver stops input at the next tick after one result.
// Reset (synchronous, active low) clears all sound state and the
// configuration to step 1/1, mono, beeper volume 15.
module psg_three_channel_sound_generator
    import psg_pkg::*;
#(
    parameter int PERIOD_BITS = 32,
    parameter int LFSR_BITS   = 17
) (
    input logic i_clk,
    input logic i_rst_n,
    psg_in_if.sink    in_ch,
    psg_out_if.source out_ch,
    psg_cfg_if.sink   cfg_ch
);

    logic [15:0] r_step_num, r_step_den;
    logic [1:0]  r_stereo;
    logic [3:0]  r_beep_vol;
    logic        r_out_valid;
    t_cmd        cmd;
    t_stat       stat;
    logic [VOL_BITS-1:0] lv [6];

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_num <= 16'd1;
            r_step_den <= 16'd1;
            r_stereo   <= 2'd0;
            r_beep_vol <= 4'd15;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                CFG_STEP_NUM: r_step_num <= cfg_ch.data;
                CFG_STEP_DEN: r_step_den <= cfg_ch.data;
                CFG_STEREO:   r_stereo   <= cfg_ch.data[1:0];
                CFG_BEEP_VOL: r_beep_vol <= cfg_ch.data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.tick) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    psg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (r_out_valid && !out_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    psg_datapath #(
        .PERIOD_BITS (PERIOD_BITS),
        .LFSR_BITS   (LFSR_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (in_ch.kind),
        .i_reg_index     (in_ch.reg_index),
        .i_write_value   (in_ch.write_value),
        .i_step_num      (r_step_num),
        .i_step_den      (r_step_den),
        .i_stereo_mode   (r_stereo),
        .i_beeper_volume (r_beep_vol),
        .o_lv            (lv)
    );

    assign out_ch.valid        = r_out_valid;
    assign out_ch.level_a      = lv[0];
    assign out_ch.level_b      = lv[1];
    assign out_ch.level_c      = lv[2];
    assign out_ch.beeper_level = lv[3];
    assign out_ch.left_sample  = lv[4];
    assign out_ch.right_sample = lv[5];

endmodule

// ===== hdl/psg_checker.sv =====
module psg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] left,
    input logic [14:0] right
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left) && $stable(right))
        else $error("result dropped under stall");

    // an accepted item blocks the input for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // result appears only after tick work with the input blocked
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("valid after reset");

endmodule

bind psg_three_channel_sound_generator psg_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .left      (out_ch.left_sample),
    .right     (out_ch.right_sample)
);

// ===== tb/sv/tb_psg_ifs.sv =====
`timescale 1ns / 100ps

// Channel interfaces are supplied with the RTL (psg_if.sv); this file only
// holds a small helper package that the bench imports.
package tb_psg_util;
    localparam int TICK_LATENCY = 40;
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import psg_pkg::*;
    import tb_psg_util::*;

    localparam logic [7:0] F_CONT = 8'd1, F_ATT = 8'd2, F_ALT = 8'd4;
    localparam logic [7:0] F_HOLD = 8'd8, F_UP = 8'd16, F_HELD = 8'd32;
    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    psg_in_if  in_ch ();
    psg_out_if out_ch ();
    psg_cfg_if cfg_ch ();

    psg_three_channel_sound_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [14:0] a, b, c, bp, l, r;
    } t_levels;

    // predictor state
    logic [15:0] m_num, m_den;
    logic [1:0]  m_mix;
    logic [3:0]  m_bvol;
    logic [7:0]  m_regs [14];
    logic [31:0] m_tper [3], m_tcnt [3], m_ncnt [3];
    logic [16:0] m_lfsr [3];
    logic [31:0] m_nper, m_eper;
    logic [32:0] m_ecnt;
    logic [3:0]  m_elev;
    logic [7:0]  m_eflg;
    logic [15:0] m_bon;

    t_levels pending_levels [$];
    int errors = 0;
    int n_ticks = 0;
    int n_writes = 0;
    int cycles = 0;
    logic long_hold = 1'b0;

    function automatic logic [15:0] vol16(input logic [3:0] i);
        logic [15:0] t [16];
        t = '{16'h0000, 16'h0344, 16'h04BC, 16'h06ED, 16'h0A3B, 16'h0F23,
              16'h1515, 16'h2277, 16'h2898, 16'h4142, 16'h5B2B, 16'h726C,
              16'h9069, 16'hB555, 16'hD79B, 16'hFFFF};
        return t[i] >> 1;
    endfunction

    function automatic logic [31:0] scaled(input logic [63:0] raw);
        logic [63:0] d;
        d = (m_den == 0) ? 64'd1 : {48'd0, m_den};
        return 32'((raw * {48'd0, m_num}) / d);
    endfunction

    task automatic model_reset();
        m_num = 1; m_den = 1; m_mix = 0; m_bvol = 15;
        for (int i = 0; i < 14; i++) m_regs[i] = 0;
        for (int i = 0; i < 3; i++) begin
            m_tper[i] = 0; m_tcnt[i] = 0; m_ncnt[i] = 0; m_lfsr[i] = 1;
        end
        m_nper = 0; m_eper = 0; m_ecnt = 0; m_elev = 0; m_eflg = 0; m_bon = 0;
    endtask

    task automatic model_reg_write(input logic [3:0] r, input logic [7:0] v);
        logic [31:0] p;
        logic [3:0] sh;
        logic [7:0] f;
        int ch;
        if (r > REG_SHAPE) return;
        m_regs[r] = v;
        if (r < REG_NOISE) begin
            ch = r >> 1;
            m_regs[ch*2+1] &= 8'h0f;
            p = scaled(64'(m_regs[ch*2]) + 256 * 64'(m_regs[ch*2+1]));
            if (p == 0) p = scaled(1);
            m_tper[ch] = p;
        end else if (r == REG_NOISE) begin
            m_regs[6] &= 8'h1f;
            p = scaled(64'(m_regs[6]));
            if (p == 0) p = scaled(1);
            m_nper = p;
        end else if (r >= REG_VOL_A && r <= REG_VOL_C) begin
            m_regs[r] &= 8'h1f;
        end else if (r == REG_ENV_LO || r == REG_ENV_HI) begin
            p = scaled(64'(m_regs[11]) + 256 * 64'(m_regs[12]));
            if (p == 0) p = scaled(1) / 2;
            m_eper = p;
        end else if (r == REG_SHAPE) begin
            sh = m_regs[13][3:0];
            f = m_eflg & (F_ALT | F_HOLD);
            m_regs[13] = {4'd0, sh};
            if (sh > 7) f = (sh[1] ? F_ALT : 8'd0) | (sh[0] ? F_HOLD : 8'd0);
            if (sh[3]) f |= F_CONT;
            if (sh[2]) f |= F_ATT | F_UP;
            m_eflg = f;
            m_ecnt = 0;
            m_elev = sh[2] ? 4'd0 : 4'd15;
        end
    endtask

    task automatic model_envelope();
        logic [32:0] lim;
        if (m_eflg & F_HELD) return;
        lim = (m_eflg & F_ALT) ? {1'b0, m_eper} : {m_eper, 1'b0};
        if (lim > m_ecnt) begin
            m_ecnt++;
            return;
        end
        m_ecnt = 0;
        if (m_eflg & F_UP) begin
            if (m_elev < 15) m_elev++;
            else if (!(m_eflg & F_CONT)) begin
                m_eflg |= F_HELD; m_elev = 0;
            end else if (m_eflg & F_HOLD) begin
                if (m_eflg & F_ALT) m_elev = 0;
                m_eflg |= F_HELD;
            end else if (m_eflg & F_ALT) m_eflg &= ~F_UP;
            else m_elev = 0;
        end else begin
            if (m_elev > 0) m_elev--;
            else if (!(m_eflg & F_CONT)) m_eflg |= F_HELD;
            else if (m_eflg & F_HOLD) begin
                if (m_eflg & F_ALT) m_elev = 15;
                m_eflg |= F_HELD;
            end else if (m_eflg & F_ALT) m_eflg |= F_UP;
            else m_elev = 15;
        end
    endtask

    function automatic logic [15:0] model_channel(input int ch);
        logic tone, noise, on;
        logic [16:0] s;
        if (m_tcnt[ch] >= m_tper[ch]) m_tcnt[ch] = 0;
        tone = m_tcnt[ch] < (m_tper[ch] / 2);
        m_tcnt[ch]++;
        if (m_ncnt[ch] >= m_nper) begin
            s = m_lfsr[ch];
            m_ncnt[ch] = 0;
            m_lfsr[ch] = {s[0] ^ s[3], s[16:1]};
        end
        noise = m_lfsr[ch][0];
        m_ncnt[ch]++;
        on = ((tone || m_regs[7][ch]) && (noise || m_regs[7][ch+3]))
             || m_tper[ch] == 0;
        if (!on) return 0;
        return m_regs[8+ch][4] ? vol16(m_elev) : vol16(m_regs[8+ch][3:0]);
    endfunction

    task automatic model_item(input logic [1:0] k, input logic [3:0] r,
                              input logic [7:0] v);
        t_levels e;
        logic [15:0] a, b, c, bp, l, rr;
        if (k == KIND_REG) model_reg_write(r, v);
        else if (k == KIND_BEEP) m_bon = (v != 0) ? vol16(m_bvol) : 16'd0;
        else if (k == KIND_TICK) begin
            model_envelope();
            a = model_channel(0); b = model_channel(1); c = model_channel(2);
            bp = m_bon;
            if (m_mix == MIX_ABC) begin
                l = a/3 + b/3 + bp/3; rr = c/3 + b/3 + bp/3;
            end else if (m_mix == MIX_ACB) begin
                l = a/3 + c/3 + bp/3; rr = b/3 + c/3 + bp/3;
            end else begin
                l = a/4 + b/4 + c/4 + bp/4; rr = l;
            end
            e = '{a[14:0], b[14:0], c[14:0], bp[14:0], l[14:0], rr[14:0]};
            pending_levels.push_back(e);
        end
    endtask

    // initial input values
    initial begin
        in_ch.valid = 0; in_ch.kind = 0; in_ch.reg_index = 0; in_ch.write_value = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        out_ch.ready = 0;
    end

    // receiver: stall pattern plus one long hold-off
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (long_hold) out_ch.ready <= 1'b0;
        else if (stall_phase[8]) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // check results
    always @(posedge i_clk) begin
        t_levels got, want;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.level_a, out_ch.level_b, out_ch.level_c,
                    out_ch.beeper_level, out_ch.left_sample, out_ch.right_sample};
            if (pending_levels.size() == 0) begin
                $display("%0t: expected no result, actual %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = pending_levels.pop_front();
                if (got !== want) begin
                    $display("%0t: expected a=%h b=%h c=%h bp=%h l=%h r=%h", $time,
                             want.a, want.b, want.c, want.bp, want.l, want.r);
                    $display("%0t: actual   a=%h b=%h c=%h bp=%h l=%h r=%h", $time,
                             got.a, got.b, got.c, got.bp, got.l, got.r);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] k, input logic [3:0] r,
                             input logic [7:0] v);
        in_ch.valid <= 1'b1;
        in_ch.kind <= k; in_ch.reg_index <= r; in_ch.write_value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model_item(k, r, v);
        if (k == KIND_TICK) n_ticks++; else n_writes++;
    endtask

    task automatic pause_sender(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (TICK_LATENCY * 2) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [15:0] d);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_STEP_NUM: m_num = d;
            CFG_STEP_DEN: m_den = d;
            CFG_STEREO:   m_mix = d[1:0];
            default:      m_bvol = d[3:0];
        endcase
    endtask

    typedef struct {
        logic [1:0] k;
        logic [3:0] r;
        logic [7:0] v;
        logic       known;
        t_levels    lv;
    } t_row;

    // random item biased toward ticks and meaningful registers
    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) send_item(KIND_TICK, 4'($urandom), 8'($urandom));
        else if (sel < 62) send_item(KIND_BEEP, 4'($urandom), 8'($urandom_range(0, 1) ?
                                     $urandom : 0));
        else if (sel < 64) send_item(2'd3, 4'($urandom), 8'($urandom));
        else if (sel < 68) send_item(KIND_REG, 4'($urandom_range(14, 15)), 8'($urandom));
        else if (sel < 80) send_item(KIND_REG, 4'($urandom_range(0, 5)),
                                     ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                                     8'($urandom_range(0, 3)));
        else send_item(KIND_REG, 4'($urandom_range(6, 13)), 8'($urandom));
    endtask

    initial begin
        t_row rows [$];
        t_row row;
        t_levels got;
        int burst;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset tick, volumes, extremes, envelope shapes, beeper, unused registers and kind
        rows.push_back('{KIND_TICK, 4'd0, 8'd0, 1'b1, '0});
        rows.push_back('{KIND_BEEP, 4'd0, 8'hff, 1'b0, '0});
        rows.push_back('{KIND_TICK, 4'd0, 8'd0, 1'b1,
                        '{15'h0, 15'h0, 15'h0, 15'h7fff, 15'h1fff, 15'h1fff}});
        rows.push_back('{KIND_REG, REG_VOL_A, 8'hff, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd9, 8'h0f, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_VOL_C, 8'h01, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd0, 8'hff, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd1, 8'hff, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd2, 8'h00, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd4, 8'h03, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_NOISE, 8'hff, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_MIXER, 8'h38, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_ENV_LO, 8'h00, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_ENV_HI, 8'h00, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_SHAPE, 8'hfe, 1'b0, '0});
        rows.push_back('{KIND_TICK, 4'd0, 8'd0, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_SHAPE, 8'h03, 1'b0, '0});
        rows.push_back('{KIND_TICK, 4'd0, 8'd0, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd14, 8'h55, 1'b0, '0});
        rows.push_back('{KIND_REG, 4'd15, 8'haa, 1'b0, '0});
        rows.push_back('{2'd3, 4'd0, 8'd0, 1'b0, '0});
        rows.push_back('{KIND_REG, REG_MIXER, 8'h00, 1'b0, '0});
        rows.push_back('{KIND_BEEP, 4'd0, 8'h00, 1'b0, '0});
        rows.push_back('{KIND_TICK, 4'd0, 8'd0, 1'b0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.known) begin
                model_item(row.k, row.r, row.v);
                got = pending_levels.pop_back();
                if (got !== row.lv)
                    $display("%0t: directed row %0d predictor expected %h actual %h",
                             $time, i, row.lv, got);
                if (got !== row.lv) errors++;
                pending_levels.push_back(row.lv);
                in_ch.valid <= 1'b1;
                in_ch.kind <= row.k; in_ch.reg_index <= row.r;
                in_ch.write_value <= row.v;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                n_ticks++;
            end else begin
                send_item(row.k, row.r, row.v);
            end
        end
        drain();

        // phases over configuration settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_STEP_NUM, 16'd1); write_cfg(CFG_STEP_DEN, 16'd1);
                          write_cfg(CFG_STEREO, 16'(MIX_ABC));
                          write_cfg(CFG_BEEP_VOL, 16'd0); end
                1: begin write_cfg(CFG_STEP_NUM, 16'hffff); write_cfg(CFG_STEP_DEN, 16'hffff);
                          write_cfg(CFG_STEREO, 16'(MIX_ACB));
                          write_cfg(CFG_BEEP_VOL, 16'd15); end
                2: begin write_cfg(CFG_STEP_NUM, 16'd1); write_cfg(CFG_STEP_DEN, 16'hffff);
                          write_cfg(CFG_STEREO, 16'd0); write_cfg(CFG_BEEP_VOL, 16'd7); end
                3: begin write_cfg(CFG_STEP_NUM, 16'd3); write_cfg(CFG_STEP_DEN, 16'd2);
                          write_cfg(CFG_STEREO, 16'd3); end
                4: begin write_cfg(CFG_STEP_NUM, 16'($urandom_range(1, 65535)));
                          write_cfg(CFG_STEP_DEN, 16'($urandom_range(1, 65535)));
                          write_cfg(CFG_STEREO, 16'($urandom_range(0, 2)));
                          write_cfg(CFG_BEEP_VOL, 16'($urandom_range(0, 15))); end
                default: begin write_cfg(CFG_STEP_NUM, 16'd1);
                          write_cfg(CFG_STEP_DEN, 16'd0); end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (ph == 2) begin
                long_hold <= 1'b1;
                fork
                    begin repeat (400) @(posedge i_clk); long_hold <= 1'b0; end
                join_none
            end
            for (int n = 0; n < 135; ) begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst; j++) random_item();
                n += burst;
                if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 30));
                if (n > 60 && n < 80 && ph == 3) begin
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_levels.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("%0d ticks and %0d writes sent over 6 settings of scaling and mix",
                 n_ticks, n_writes);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
